// ----- sv/mbce_pkg.sv -----
// shared types, constants and register codes of the bitmap color expander
package mbce_pkg;

  localparam int MAX_WIDTH_DEF  = 255;
  localparam int MAX_HEIGHT_DEF = 255;

  localparam int COLOR_W = 16;
  localparam int ORG_W   = 9;
  localparam int DIM_W   = 8;
  localparam int COORD_W = 10;
  localparam int LIM_W   = 10;
  localparam int COL_W   = 5;
  localparam int ROW_W   = 8;
  localparam int BITS    = 8;
  localparam int BIT_IDX_W = 3;
  localparam int CFG_IDX_W = 3;

  localparam logic [COLOR_W-1:0] FG_RESET     = 16'h0000;
  localparam logic [COLOR_W-1:0] BG_RESET     = 16'hFFFF;
  localparam logic [DIM_W-1:0]   WIDTH_RESET  = 8'd8;
  localparam logic [DIM_W-1:0]   HEIGHT_RESET = 8'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FG_COLOR     = 3'd0,
    REG_BG_COLOR     = 3'd1,
    REG_ORIGIN_X     = 3'd2,
    REG_ORIGIN_Y     = 3'd3,
    REG_IMAGE_WIDTH  = 3'd4,
    REG_IMAGE_HEIGHT = 3'd5,
    REG_OPAQUE_MODE  = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [COLOR_W-1:0] fg_color;
    logic [COLOR_W-1:0] bg_color;
    logic [ORG_W-1:0]   origin_x;
    logic [ORG_W-1:0]   origin_y;
    logic [DIM_W-1:0]   image_width;
    logic [DIM_W-1:0]   image_height;
    logic               opaque_mode;
  } cfg_t;

  typedef struct packed {
    logic [BITS-1:0]    mask;
    logic [BITS-1:0]    bits;
    logic [COORD_W-1:0] base_x;
    logic [COORD_W-1:0] y;
    logic               last_img;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ----- sv/mbce_in_if.sv -----
// input channel carrying one bitmap byte per word
interface mbce_in_if import mbce_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [BITS-1:0] bitmap_byte;

  modport source (output valid, output bitmap_byte, input ready);
  modport sink (input valid, input bitmap_byte, output ready);
endinterface

// ----- sv/mbce_pix_if.sv -----
// output channel carrying one pixel per word
interface mbce_pix_if import mbce_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] pixel_color;
  logic [COORD_W-1:0] pixel_x;
  logic [COORD_W-1:0] pixel_y;
  logic               last_of_byte;
  logic               last_of_image;

  modport source (output valid, output pixel_color, output pixel_x, output pixel_y,
                  output last_of_byte, output last_of_image, input ready);
  modport sink (input valid, input pixel_color, input pixel_x, input pixel_y,
                input last_of_byte, input last_of_image, output ready);
endinterface

// ----- sv/mbce_cfg_if.sv -----
// configuration write channel
interface mbce_cfg_if import mbce_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [COLOR_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- sv/mbce_front.sv -----
// front end: byte position tracking and pixel mask classification
module mbce_front import mbce_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    in_valid,
  input  logic [BITS-1:0] in_byte,
  output logic    in_ready,
  input  q_stat_t q_stat,
  output logic    push,
  output job_t    push_job
);

  logic [COL_W-1:0] byte_column, byte_column_next;
  logic [ROW_W-1:0] row_index, row_index_next;
  logic [DIM_W-1:0] w_lim, h_lim;
  logic [5:0]       nbytes;
  logic             last_col, last_row, accept;
  logic [BITS-1:0]  cnt_mask;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    if ({2'b0, cfg.image_width} > LIM_W'(MAX_WIDTH)) begin
      w_lim = DIM_W'(MAX_WIDTH);
    end else begin
      w_lim = cfg.image_width;
    end
    if ({2'b0, cfg.image_height} > LIM_W'(MAX_HEIGHT)) begin
      h_lim = DIM_W'(MAX_HEIGHT);
    end else begin
      h_lim = cfg.image_height;
    end
    if (h_lim == '0) begin
      h_lim = DIM_W'(1);
    end
    nbytes   = 6'(({1'b0, w_lim} + 9'd7) >> 3);
    last_col = (nbytes == '0) || (({1'b0, byte_column} + 6'd1) >= nbytes);
    last_row = (({1'b0, row_index} + 9'd1) >= {1'b0, h_lim});
    if (w_lim == '0) begin
      cnt_mask = '0;
    end else if (last_col && (w_lim[2:0] != 3'd0)) begin
      cnt_mask = 8'hFF >> (3'd0 - w_lim[2:0]);
    end else begin
      cnt_mask = 8'hFF;
    end
  end

  always_comb begin
    push_job.mask     = cnt_mask & (cfg.opaque_mode ? 8'hFF : in_byte);
    push_job.bits     = in_byte;
    push_job.base_x   = {1'b0, cfg.origin_x} + {2'b0, byte_column, 3'b000};
    push_job.y        = {1'b0, cfg.origin_y} + {2'b0, row_index};
    push_job.last_img = last_col && last_row;
    push              = accept && (push_job.mask != '0);
  end

  always_comb begin
    byte_column_next = byte_column;
    row_index_next   = row_index;
    if (accept) begin
      if (last_col) begin
        byte_column_next = '0;
        row_index_next   = last_row ? '0 : row_index + ROW_W'(1);
      end else begin
        byte_column_next = byte_column + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_column <= '0;
      row_index   <= '0;
    end else begin
      byte_column <= byte_column_next;
      row_index   <= row_index_next;
    end
  end

endmodule

// ----- sv/mbce_queue.sv -----
// two-entry queue of byte jobs between front and back
module mbce_queue import mbce_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  job_t    push_job,
  input  logic    pop,
  output job_t    head,
  output q_stat_t stat
);

  job_t       slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign stat.full  = (count == 2'd2);
  assign stat.empty = (count == 2'd0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ----- sv/mbce_back.sv -----
// back end: walks the pixel mask of one byte, one pixel per cycle while the pixel port is not stalled
module mbce_back import mbce_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  job_t    head,
  input  q_stat_t q_stat,
  output logic    pop,
  mbce_pix_if.source pix
);

  job_t               cur;
  logic               cur_valid;
  logic [BITS-1:0]    rest;
  logic [BIT_IDX_W-1:0] k;
  logic               slot_free, emit, load;

  always_comb begin
    k = '0;
    for (int i = BITS - 1; i >= 0; i--) begin
      if (cur.mask[i]) begin
        k = BIT_IDX_W'(i);
      end
    end
  end

  assign rest      = cur.mask & (cur.mask - BITS'(1));
  assign slot_free = !pix.valid || pix.ready;
  assign emit      = cur_valid && slot_free;
  assign load      = !q_stat.empty && (!cur_valid || (emit && (rest == '0)));
  assign pop       = load;

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= head;
    end else if (emit) begin
      cur.mask <= rest;
    end
    if (emit) begin
      pix.pixel_color   <= cur.bits[k] ? cfg.fg_color : cfg.bg_color;
      pix.pixel_x       <= cur.base_x + COORD_W'(k);
      pix.pixel_y       <= cur.y;
      pix.last_of_byte  <= (rest == '0);
      pix.last_of_image <= (rest == '0) && cur.last_img;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      pix.valid <= 1'b0;
    end else begin
      if (load) begin
        cur_valid <= 1'b1;
      end else if (emit && (rest == '0)) begin
        cur_valid <= 1'b0;
      end
      if (emit) begin
        pix.valid <= 1'b1;
      end else if (pix.ready) begin
        pix.valid <= 1'b0;
      end
    end
  end

endmodule

// ----- sv/mono_bitmap_color_expander_core.sv -----
// top level of the monochrome bitmap color expander
//
//   channel   dir  word contents
//   in_ch     in   bitmap_byte (8 bits, bit 0 leftmost)
//   pix_ch    out  pixel_color, pixel_x, pixel_y, last_of_byte, last_of_image
//   cfg_ch    in   index (3 bits), data (16 bits), always ready
//
// one byte is taken per cycle while the two-word job queue has room
// the pixel walker sends one pixel per cycle while the pixel port is not stalled;
// a byte yields 0 to 8 pixels; bytes that yield no pixel never enter the queue
// rst is synchronous: counters and queue clear, registers return to reset values
// a stalled pixel port fills the queue, then in_ch.ready drops
module mono_bitmap_color_expander_core import mbce_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input logic clk,
  input logic rst,
  mbce_in_if.sink    in_ch,
  mbce_pix_if.source pix_ch,
  mbce_cfg_if.sink   cfg_ch
);

  cfg_t    cfg;
  job_t    push_job, head;
  logic    push, pop;
  q_stat_t q_stat;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fg_color     <= FG_RESET;
      cfg.bg_color     <= BG_RESET;
      cfg.origin_x     <= '0;
      cfg.origin_y     <= '0;
      cfg.image_width  <= WIDTH_RESET;
      cfg.image_height <= HEIGHT_RESET;
      cfg.opaque_mode  <= 1'b1;
    end else if (cfg_ch.valid) begin
      case (reg_idx_t'(cfg_ch.index))
        REG_FG_COLOR:     cfg.fg_color     <= cfg_ch.data;
        REG_BG_COLOR:     cfg.bg_color     <= cfg_ch.data;
        REG_ORIGIN_X:     cfg.origin_x     <= cfg_ch.data[ORG_W-1:0];
        REG_ORIGIN_Y:     cfg.origin_y     <= cfg_ch.data[ORG_W-1:0];
        REG_IMAGE_WIDTH:  cfg.image_width  <= cfg_ch.data[DIM_W-1:0];
        REG_IMAGE_HEIGHT: cfg.image_height <= cfg_ch.data[DIM_W-1:0];
        REG_OPAQUE_MODE:  cfg.opaque_mode  <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  mbce_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_ch.valid),
    .in_byte  (in_ch.bitmap_byte),
    .in_ready (in_ch.ready),
    .q_stat   (q_stat),
    .push     (push),
    .push_job (push_job)
  );

  mbce_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  mbce_back u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .pix    (pix_ch)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_stat.full)
    else $error("job queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("job queue read while empty");

  a_image_end_closes_byte: assert property (@(posedge clk) disable iff (rst)
    (pix_ch.valid && pix_ch.last_of_image) |-> pix_ch.last_of_byte)
    else $error("image end flagged on a pixel that does not close its byte");

  a_quiet_after_reset: assert property (@(posedge clk)
    rst |=> !pix_ch.valid)
    else $error("pixel word valid right after reset");

endmodule

// ----- test/tb_top.sv -----
// self-checking testbench for the bitmap color expander: directed table, then random images
`timescale 1ns / 1ps

module tb_top import mbce_pkg::*; ();

  localparam int SETTLE     = 24;
  localparam int TAIL       = 60;
  localparam int TIMEOUT_NS = 2_000_000;
  localparam int RANDOM_BYTES = 110;
  localparam int CALM_AFTER   = 88;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic                 is_reg;
    logic [CFG_IDX_W-1:0] idx;
    logic [COLOR_W-1:0]   val;
    logic                 typed;
    logic [3:0]           n;
    logic [COLOR_W-1:0]   color;
    logic [COORD_W-1:0]   x0;
    logic [COORD_W-1:0]   y;
    logic                 last_img;
  } step_t;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               last_byte;
    logic               last_img;
  } pixel_t;

  logic clk;
  logic rst;
  bit   calm;
  int   mismatches;

  mbce_in_if  in_ch ();
  mbce_pix_if pix_ch ();
  mbce_cfg_if cfg_ch ();

  mono_bitmap_color_expander_core u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .pix_ch (pix_ch),
    .cfg_ch (cfg_ch)
  );

  // expander state as the block should hold it
  logic [COLOR_W-1:0] cur_fg;
  logic [COLOR_W-1:0] cur_bg;
  logic [ORG_W-1:0]   cur_ox;
  logic [ORG_W-1:0]   cur_oy;
  logic [DIM_W-1:0]   cur_w;
  logic [DIM_W-1:0]   cur_h;
  logic               cur_opaque;
  logic [COL_W-1:0]   col_pos;
  logic [ROW_W-1:0]   row_pos;

  pixel_t pending_pixels [$];
  step_t  byte_notes [$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("TEST FAILED");
    $finish;
  end

  task automatic report_mismatch(string what, logic [COLOR_W-1:0] got,
                                 logic [COLOR_W-1:0] want);
    mismatches++;
    $display("%0t: %s got %h want %h", $time, what, got, want);
  endtask

  task automatic apply_reg(logic [CFG_IDX_W-1:0] idx, logic [COLOR_W-1:0] val);
    case (idx)
      REG_FG_COLOR:     cur_fg = val;
      REG_BG_COLOR:     cur_bg = val;
      REG_ORIGIN_X:     cur_ox = val[ORG_W-1:0];
      REG_ORIGIN_Y:     cur_oy = val[ORG_W-1:0];
      REG_IMAGE_WIDTH:  cur_w = val[DIM_W-1:0];
      REG_IMAGE_HEIGHT: cur_h = val[DIM_W-1:0];
      REG_OPAQUE_MODE:  cur_opaque = val[0];
      default: ;
    endcase
  endtask

  task automatic expand_byte(logic [BITS-1:0] data, step_t note);
    pixel_t px [$];
    pixel_t p;
    int w, h, nb, cnt, k, last;
    bit last_col, last_row;
    w = int'(cur_w);
    h = int'(cur_h);
    if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
    if (h > MAX_HEIGHT_DEF) h = MAX_HEIGHT_DEF;
    if (h == 0) h = 1;
    nb = (w + 7) / 8;
    last_col = (nb == 0) || (int'(col_pos) + 1 >= nb);
    last_row = int'(row_pos) + 1 >= h;
    if (w == 0) cnt = 0;
    else if (last_col && (w % 8) != 0) cnt = w % 8;
    else cnt = 8;
    for (k = 0; k < cnt; k++) begin
      if (data[k] || cur_opaque) begin
        p.color = data[k] ? cur_fg : cur_bg;
        p.x = COORD_W'(int'(cur_ox) + int'(col_pos) * 8 + k);
        p.y = COORD_W'(int'(cur_oy) + int'(row_pos));
        p.last_byte = 1'b0;
        p.last_img = 1'b0;
        px.push_back(p);
      end
    end
    if (px.size() > 0) begin
      last = px.size() - 1;
      p = px[last];
      p.last_byte = 1'b1;
      p.last_img = last_col && last_row;
      px[last] = p;
    end
    if (last_col) begin
      col_pos = '0;
      row_pos = last_row ? '0 : row_pos + 1'b1;
    end else begin
      col_pos = col_pos + 1'b1;
    end
    if (note.typed) begin
      for (k = 0; k < int'(note.n); k++) begin
        p.color = note.color;
        p.x = note.x0 + COORD_W'(k);
        p.y = note.y;
        p.last_byte = (k == int'(note.n) - 1);
        p.last_img = note.last_img && (k == int'(note.n) - 1);
        pending_pixels.push_back(p);
      end
    end else begin
      foreach (px[i]) pending_pixels.push_back(px[i]);
    end
  endtask

  always @(posedge clk) begin
    pixel_t want;
    if (rst) begin
      cur_fg = FG_RESET;
      cur_bg = BG_RESET;
      cur_ox = '0;
      cur_oy = '0;
      cur_w = WIDTH_RESET;
      cur_h = HEIGHT_RESET;
      cur_opaque = 1'b1;
      col_pos = '0;
      row_pos = '0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) apply_reg(cfg_ch.index, cfg_ch.data);
      if (in_ch.valid && in_ch.ready) expand_byte(in_ch.bitmap_byte, byte_notes.pop_front());
      if (pix_ch.valid && pix_ch.ready) begin
        if (pending_pixels.size() == 0) begin
          report_mismatch("pixel with none expected, color", pix_ch.pixel_color, '0);
        end else begin
          want = pending_pixels.pop_front();
          if (pix_ch.pixel_color !== want.color)
            report_mismatch("pixel_color", pix_ch.pixel_color, want.color);
          if (pix_ch.pixel_x !== want.x)
            report_mismatch("pixel_x", COLOR_W'(pix_ch.pixel_x), COLOR_W'(want.x));
          if (pix_ch.pixel_y !== want.y)
            report_mismatch("pixel_y", COLOR_W'(pix_ch.pixel_y), COLOR_W'(want.y));
          if (pix_ch.last_of_byte !== want.last_byte)
            report_mismatch("last_of_byte", COLOR_W'(pix_ch.last_of_byte),
                            COLOR_W'(want.last_byte));
          if (pix_ch.last_of_image !== want.last_img)
            report_mismatch("last_of_image", COLOR_W'(pix_ch.last_of_image),
                            COLOR_W'(want.last_img));
        end
      end
    end
  end

  // pixel port stalls in bursts
  initial begin
    bit r;
    int n;
    pix_ch.ready <= 1'b0;
    forever begin
      r = calm || ($urandom_range(0, 2) != 0);
      n = r ? $urandom_range(1, 20) : $urandom_range(1, 10);
      repeat (n) begin
        @(posedge clk);
        pix_ch.ready <= r || calm;
      end
    end
  end

  function automatic step_t wr(logic [CFG_IDX_W-1:0] idx, logic [COLOR_W-1:0] val);
    step_t s;
    s = '0;
    s.is_reg = 1'b1;
    s.idx = idx;
    s.val = val;
    return s;
  endfunction

  function automatic step_t bt(logic [BITS-1:0] v);
    step_t s;
    s = '0;
    s.val = COLOR_W'(v);
    return s;
  endfunction

  function automatic step_t bt_exp(logic [BITS-1:0] v, int n, logic [COLOR_W-1:0] color,
                                   int x0, int y, bit last_img);
    step_t s;
    s = bt(v);
    s.typed = 1'b1;
    s.n = 4'(n);
    s.color = color;
    s.x0 = COORD_W'(x0);
    s.y = COORD_W'(y);
    s.last_img = last_img;
    return s;
  endfunction

  // the queue check waits until the monitor has logged the last accepted byte
  task automatic wait_drained(int extra);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COLOR_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    @(posedge clk);
    while (!(cfg_ch.valid && cfg_ch.ready)) @(posedge clk);
  endtask

  task automatic send_byte(logic [BITS-1:0] b, step_t note);
    byte_notes.push_back(note);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.bitmap_byte <= b;
    @(posedge clk);
    while (!(in_ch.valid && in_ch.ready)) @(posedge clk);
  endtask

  initial begin : stimulus
    step_t plan [$];
    logic [DIM_W-1:0] w, h;
    logic [BITS-1:0] b;
    int nbytes, nb, eff_h, phase, random_sent, i;
    bit cfg_open;
    in_ch.valid <= 1'b0;
    in_ch.bitmap_byte <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data <= '0;
    rst <= 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values: 8x8 opaque, fg 0, bg ffff, origin 0
    plan.push_back(bt_exp(8'h00, 8, 16'hFFFF, 0, 0, 0));
    plan.push_back(bt_exp(8'hFF, 8, 16'h0000, 0, 1, 0));
    plan.push_back(bt(8'h5A));
    // shrink the image under the counters, origin at its top
    plan.push_back(wr(REG_FG_COLOR, 16'hFFFF));
    plan.push_back(wr(REG_BG_COLOR, 16'h0000));
    plan.push_back(wr(REG_ORIGIN_X, 16'hFFFF));
    plan.push_back(wr(REG_ORIGIN_Y, 16'h01FF));
    plan.push_back(wr(REG_IMAGE_WIDTH, 16'd13));
    plan.push_back(wr(REG_IMAGE_HEIGHT, 16'd2));
    plan.push_back(bt(8'hC3));
    plan.push_back(bt(8'hFF));
    plan.push_back(bt_exp(8'hFF, 8, 16'hFFFF, 511, 511, 0));
    plan.push_back(bt_exp(8'h00, 5, 16'h0000, 519, 511, 0));
    plan.push_back(bt(8'h81));
    plan.push_back(bt(8'h1F));
    // transparent, last byte with no set bit
    plan.push_back(wr(REG_OPAQUE_MODE, 16'h0000));
    plan.push_back(wr(REG_IMAGE_WIDTH, 16'd16));
    plan.push_back(bt_exp(8'h00, 0, 16'h0000, 0, 0, 0));
    plan.push_back(bt(8'h80));
    plan.push_back(bt(8'h01));
    plan.push_back(bt_exp(8'h00, 0, 16'h0000, 0, 0, 0));
    // zero width and zero height
    plan.push_back(wr(REG_IMAGE_WIDTH, 16'd0));
    plan.push_back(wr(REG_IMAGE_HEIGHT, 16'd0));
    plan.push_back(bt_exp(8'hFF, 0, 16'h0000, 0, 0, 0));
    plan.push_back(bt_exp(8'hA5, 0, 16'h0000, 0, 0, 0));
    plan.push_back(wr(REG_OPAQUE_MODE, 16'hFFFF));
    plan.push_back(wr(REG_IMAGE_WIDTH, 16'hFF01));
    plan.push_back(wr(REG_ORIGIN_X, 16'h0000));
    plan.push_back(wr(REG_ORIGIN_Y, 16'h0000));
    plan.push_back(wr(REG_UNUSED, 16'hFFFF));
    plan.push_back(bt_exp(8'hFE, 1, 16'h0000, 0, 0, 1));
    plan.push_back(bt_exp(8'h01, 1, 16'hFFFF, 0, 0, 1));
    plan.push_back(wr(REG_IMAGE_WIDTH, 16'd7));
    plan.push_back(wr(REG_IMAGE_HEIGHT, 16'd255));
    plan.push_back(bt(8'h80));
    plan.push_back(bt(8'h7F));

    cfg_open = 1'b0;
    foreach (plan[j]) begin
      if (plan[j].is_reg) begin
        if (!cfg_open) begin
          wait_drained(SETTLE);
          cfg_open = 1'b1;
        end
        write_reg(plan[j].idx, plan[j].val);
      end else begin
        if (cfg_open) begin
          cfg_ch.valid <= 1'b0;
          cfg_open = 1'b0;
        end
        send_byte(plan[j].val[BITS-1:0], plan[j]);
      end
    end

    random_sent = 0;
    phase = 0;
    while (random_sent < RANDOM_BYTES) begin
      wait_drained(SETTLE);
      case ($urandom_range(0, 15))
        0:       w = 8'd0;
        1:       w = 8'd255;
        2:       w = 8'd1;
        default: w = DIM_W'($urandom_range(1, 24));
      endcase
      case ($urandom_range(0, 11))
        0:       h = 8'd0;
        1:       h = 8'd255;
        default: h = DIM_W'($urandom_range(1, 4));
      endcase
      write_reg(REG_IMAGE_WIDTH, {8'($urandom), w});
      write_reg(REG_IMAGE_HEIGHT, {8'($urandom), h});
      if ($urandom_range(0, 1)) write_reg(REG_FG_COLOR, 16'($urandom));
      if ($urandom_range(0, 1)) write_reg(REG_BG_COLOR, 16'($urandom));
      if ($urandom_range(0, 1)) write_reg(REG_ORIGIN_X, 16'($urandom));
      if ($urandom_range(0, 1)) write_reg(REG_ORIGIN_Y, 16'($urandom));
      if ($urandom_range(0, 1)) write_reg(REG_OPAQUE_MODE, 16'($urandom));
      if ($urandom_range(0, 7) == 0) write_reg(REG_UNUSED, 16'($urandom));
      cfg_ch.valid <= 1'b0;

      // finish the image in progress, sometimes one more whole image, sometimes stop short of its end
      nb = (int'(w) + 7) / 8;
      eff_h = (h == 0) ? 1 : int'(h);
      if (nb == 0) begin
        nbytes = $urandom_range(1, 4);
      end else begin
        nbytes = (int'(col_pos) + 1 >= nb) ? 1 : nb - int'(col_pos);
        if (int'(row_pos) + 1 < eff_h) nbytes += (eff_h - int'(row_pos) - 1) * nb;
        if (nb * eff_h <= 12 && $urandom_range(0, 1) == 1) nbytes += nb * eff_h;
      end
      if ($urandom_range(0, 4) == 0) nbytes = $urandom_range(1, nbytes);
      if (nbytes > 40) nbytes = 40;
      if (nbytes > RANDOM_BYTES - random_sent) nbytes = RANDOM_BYTES - random_sent;

      for (i = 0; i < nbytes; i++) begin
        if (phase == 2 && i == nbytes / 2) wait_drained(1);
        case ($urandom_range(0, 7))
          0:       b = 8'h00;
          1:       b = 8'hFF;
          default: b = BITS'($urandom);
        endcase
        send_byte(b, bt(b));
        random_sent++;
        if (random_sent >= CALM_AFTER) calm = 1'b1;
      end
      phase++;
    end

    wait_drained(TAIL);
    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/mbce_pkg.sv
sv/mbce_in_if.sv
sv/mbce_pix_if.sv
sv/mbce_cfg_if.sv
sv/mbce_front.sv
sv/mbce_queue.sv
sv/mbce_back.sv
sv/mono_bitmap_color_expander_core.sv
test/tb_top.sv
